>>> hdl/height_gradient_color_mapper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the height gradient color mapper
// Implication checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_GRADIENT_COLOR_MAPPER_ASSERT_SVH
`define HEIGHT_GRADIENT_COLOR_MAPPER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HGCM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define HGCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hgcm_pkg.sv
// ----------------------------------------------------------------------------
// hgcm_pkg
// Shared constants and types of the height gradient color mapper.
// ----------------------------------------------------------------------------
package hgcm_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int HEIGHT_BITS   = 16;
    localparam int DIFF_W        = HEIGHT_BITS + 1;
    localparam int MAG_W         = HEIGHT_BITS;
    localparam int CNT_W         = $clog2(FRACTION_BITS);
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 4;
    localparam int COLOR_W       = CHAN_W * NUM_CHAN;
    localparam int ACC_W         = CHAN_W + 1 + FRACTION_BITS + 1;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CHAN_W-1:0]  LEVEL_STEP  = 8'd5;
    localparam logic [CHAN_W-1:0]  LEVEL_FULL  = 8'hFF;
    localparam logic [CHAN_W-1:0]  LEVEL_ZERO  = 8'h00;
    localparam logic [COLOR_W-1:0] START_RESET = 32'hFFFF00FF;
    localparam logic [COLOR_W-1:0] END_RESET   = 32'hFF00FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 1'b1;

    localparam logic OP_HEIGHT = 1'b0;
    localparam logic OP_CYCLE  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
        logic qbit;
    } t_blend_ctl;

endpackage

>>> hdl/hgcm_div.sv
// ----------------------------------------------------------------------------
// hgcm_div
// Restoring divider, one quotient bit per cycle when loading or stepping,
// MSB first. Load gives the integer bit (saturating), each step a fraction bit.
// ----------------------------------------------------------------------------
module hgcm_div (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic [hgcm_pkg::MAG_W-1:0] i_num,
    input  logic [hgcm_pkg::MAG_W-1:0] i_den,
    output logic                      o_qbit
);
    import hgcm_pkg::*;

    logic [MAG_W-1:0] r_rem, n_rem;
    logic [MAG_W-1:0] r_den, n_den;
    logic [MAG_W:0]   w_trial;
    logic [MAG_W:0]   w_diff;

    always_comb begin
        n_rem   = r_rem;
        n_den   = r_den;
        w_trial = {r_rem, 1'b0};
        w_diff  = w_trial - {1'b0, r_den};
        o_qbit  = 1'b0;
        if (i_load) begin
            // quotient >= 1 saturates: remainder cleared so later bits are 0
            o_qbit = (i_num >= i_den);
            n_den  = i_den;
            n_rem  = o_qbit ? '0 : i_num;
        end else if (i_step) begin
            o_qbit = (w_trial >= {1'b0, r_den});
            n_rem  = o_qbit ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
    end

endmodule

>>> hdl/hgcm_blend.sv
// ----------------------------------------------------------------------------
// hgcm_blend
// Four channel interpolator fed one quotient bit per step cycle, MSB first:
// acc = 2*acc + bit*(end - start), color = start + floor(acc / 2^F).
// ----------------------------------------------------------------------------
module hgcm_blend (
    input  logic                          i_clk,
    input  hgcm_pkg::t_blend_ctl          i_ctl,
    input  logic [hgcm_pkg::COLOR_W-1:0]  i_start,
    input  logic [hgcm_pkg::COLOR_W-1:0]  i_end,
    output logic [hgcm_pkg::COLOR_W-1:0]  o_color
);
    import hgcm_pkg::*;

    localparam int HI_W = ACC_W - FRACTION_BITS;

    logic signed [ACC_W-1:0]  r_acc [NUM_CHAN];
    logic signed [ACC_W-1:0]  n_acc [NUM_CHAN];
    logic signed [CHAN_W:0]   w_s   [NUM_CHAN];
    logic signed [CHAN_W:0]   w_d   [NUM_CHAN];
    logic        [HI_W-1:0]   w_sum [NUM_CHAN];

    always_comb begin
        o_color = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_s[c] = {1'b0, i_start[c*CHAN_W +: CHAN_W]};
            w_d[c] = $signed({1'b0, i_end[c*CHAN_W +: CHAN_W]}) - w_s[c];
            n_acc[c] = r_acc[c];
            if (i_ctl.clear) begin
                n_acc[c] = '0;
            end else if (i_ctl.step) begin
                n_acc[c] = (r_acc[c] <<< 1)
                         + (i_ctl.qbit ? {{(ACC_W-CHAN_W-1){w_d[c][CHAN_W]}}, w_d[c]}
                                       : {ACC_W{1'b0}});
            end
            w_sum[c] = {{(HI_W-CHAN_W-1){1'b0}}, w_s[c]}
                     + r_acc[c][ACC_W-1:FRACTION_BITS];
            o_color[c*CHAN_W +: CHAN_W] = w_sum[c][CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            r_acc[c] <= n_acc[c];
        end
    end

endmodule

>>> hdl/height_gradient_color_mapper.sv
// ----------------------------------------------------------------------------
// height_gradient_color_mapper
// Maps a height to an RGBA8888 gradient color, or steps the palette cycle.
//
//   channel   signals                              width
//   input     i_valid/o_ready, i_op, i_height      1 + 16
//   output    o_valid/i_ready, o_color             32
//   config    i_cfg_valid/o_cfg_ready, index/data  1 + 16
//
// Height item: from accept to o_valid it passes setup, 16 divider steps and the
// load of the output register. A cycle item skips setup and the divider.
// One item in flight; o_ready is high in idle.
// A finished result waits in the output register; a new item may be taken
// meanwhile. Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
module height_gradient_color_mapper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic signed [hgcm_pkg::HEIGHT_BITS-1:0] i_height,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [hgcm_pkg::COLOR_W-1:0]         o_color,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hgcm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hgcm_pkg::HEIGHT_BITS-1:0]     i_cfg_data
);
    import hgcm_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS - 1);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_op, n_op;
    logic signed [DIFF_W-1:0] r_num, n_num;
    logic signed [DIFF_W-1:0] r_den, n_den;
    logic [HEIGHT_BITS-1:0]   r_min, n_min;
    logic [HEIGHT_BITS-1:0]   r_max, n_max;
    logic [CHAN_W-1:0]        r_red, n_red;
    logic [CHAN_W-1:0]        r_green, n_green;
    logic [CHAN_W-1:0]        r_blue, n_blue;
    logic                     r_first, n_first;
    logic [COLOR_W-1:0]       r_start, n_start;
    logic [COLOR_W-1:0]       r_end, n_end;
    logic                     r_o_valid, n_o_valid;
    logic [COLOR_W-1:0]       r_o_color, n_o_color;

    logic                     w_accept;
    logic                     w_zero;
    logic [DIFF_W-1:0]        w_num_abs;
    logic [DIFF_W-1:0]        w_den_abs;
    logic [MAG_W-1:0]         w_un;
    logic [MAG_W-1:0]         w_ud;
    logic                     w_div_load;
    logic                     w_div_step;
    logic                     w_qbit;
    t_blend_ctl               w_ctl;
    logic [COLOR_W-1:0]       w_blend;
    logic [CHAN_W-1:0]        w_r, w_g, w_b;
    logic                     w_div_last;
    logic                     w_in_done;
    logic                     w_take_height;
    logic                     w_in_setup;
    logic                     w_take_cycle;
    logic                     w_pal_ok;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_color     = r_o_color;
    assign w_accept    = i_valid && o_ready;

    // operand conditioning
    always_comb begin
        w_zero    = (r_num == '0) || (r_den == '0) || (r_num[DIFF_W-1] != r_den[DIFF_W-1]);
        w_num_abs = r_num[DIFF_W-1] ? -r_num : r_num;
        w_den_abs = r_den[DIFF_W-1] ? -r_den : r_den;
        w_un      = w_zero ? '0 : w_num_abs[MAG_W-1:0];
        w_ud      = (r_den == '0) ? MAG_W'(1) : w_den_abs[MAG_W-1:0];
    end

    // palette loop
    always_comb begin
        w_r = r_red;
        w_g = r_green;
        w_b = r_blue;
        if (r_first) begin
            w_r = LEVEL_FULL; w_g = LEVEL_FULL; w_b = LEVEL_ZERO;
        end else if (r_red != LEVEL_ZERO && r_green == LEVEL_FULL && r_blue == LEVEL_ZERO) begin
            w_r = r_red - LEVEL_STEP;
        end else if (r_red == LEVEL_ZERO && r_green == LEVEL_FULL && r_blue != LEVEL_FULL) begin
            w_b = r_blue + LEVEL_STEP;
        end else if (r_red != LEVEL_FULL && r_green == LEVEL_ZERO && r_blue == LEVEL_FULL) begin
            w_r = r_red + LEVEL_STEP;
        end else if (r_red == LEVEL_ZERO && r_green != LEVEL_ZERO && r_blue == LEVEL_FULL) begin
            w_g = r_green - LEVEL_STEP;
        end else if (r_red == LEVEL_FULL && r_green == LEVEL_ZERO && r_blue != LEVEL_ZERO) begin
            w_b = r_blue - LEVEL_STEP;
        end else begin
            w_r = LEVEL_FULL; w_g = LEVEL_FULL; w_b = LEVEL_ZERO;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_num      = r_num;
        n_den      = r_den;
        n_min      = r_min;
        n_max      = r_max;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_first    = r_first;
        n_start    = r_start;
        n_end      = r_end;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_color  = r_o_color;
        w_div_load = 1'b0;
        w_div_step = 1'b0;
        w_ctl      = '{clear: 1'b0, step: 1'b0, qbit: w_qbit};

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_HEIGHT: n_min = i_cfg_data;
                CFG_MAX_HEIGHT: n_max = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.clear = 1'b1;
                    n_op        = i_op;
                    if (i_op == OP_CYCLE) begin
                        n_red   = w_r;
                        n_green = w_g;
                        n_blue  = w_b;
                        n_first = 1'b0;
                        n_start = {w_r, w_g, w_b, LEVEL_FULL};
                        n_end   = {w_g, w_b, w_r, LEVEL_FULL};
                        n_state = S_DONE;
                    end else begin
                        n_num   = {i_height[HEIGHT_BITS-1], i_height}
                                - $signed({r_min[HEIGHT_BITS-1], r_min});
                        n_den   = $signed({r_max[HEIGHT_BITS-1], r_max})
                                - $signed({r_min[HEIGHT_BITS-1], r_min});
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                w_div_load = 1'b1;
                w_ctl.step = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                w_div_step = 1'b1;
                w_ctl.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_color = (r_op == OP_CYCLE) ? r_start : w_blend;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_red     <= LEVEL_FULL;
            r_green   <= LEVEL_FULL;
            r_blue    <= LEVEL_ZERO;
            r_first   <= 1'b1;
            r_start   <= START_RESET;
            r_end     <= END_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_min     <= n_min;
            r_max     <= n_max;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_first   <= n_first;
            r_start   <= n_start;
            r_end     <= n_end;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_num     <= n_num;
        r_den     <= n_den;
        r_o_color <= n_o_color;
    end

    hgcm_div u_div (
        .i_clk  (i_clk),
        .i_load (w_div_load),
        .i_step (w_div_step),
        .i_num  (w_un),
        .i_den  (w_ud),
        .o_qbit (w_qbit)
    );

    hgcm_blend u_blend (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_start (r_start),
        .i_end   (r_end),
        .o_color (w_blend)
    );

    assign w_div_last    = (r_state == S_DIV) && (r_cnt == CNT_LAST);
    assign w_in_done     = (r_state == S_DONE);
    assign w_take_height = w_accept && (i_op == OP_HEIGHT);
    assign w_in_setup    = (r_state == S_SETUP);
    assign w_take_cycle  = w_accept && (i_op == OP_CYCLE);
    assign w_pal_ok      = (r_start[CHAN_W-1:0] == LEVEL_FULL)
                        && (r_end[CHAN_W-1:0] == LEVEL_FULL) && !r_first;

`include "height_gradient_color_mapper_assert.svh"

    `HGCM_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, w_div_last, w_in_done, "divider overran")
    `HGCM_ASSERT_NEXT(a_height_setup, i_clk, i_rst_n, w_take_height, w_in_setup, "no setup")
    `HGCM_ASSERT_NEXT(a_cycle_alpha, i_clk, i_rst_n, w_take_cycle, w_pal_ok, "bad palette")

endmodule
